[sv/lcm_pkg.sv]
// Shared constants and types for the set-associative LRU tag store.
// No dependencies; every other file of the block refers to it by scope.
`timescale 1ns / 1ps
`default_nettype none

package lcm_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int ADDR_W    = 64;
  localparam int STAMP_W   = 64;
  localparam int CNT_W     = 32;
  localparam int OUTCOME_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int SET_BITS_W = 3;
  localparam int WAYS_CFG_W = 4;
  localparam int OFFSET_W   = 6;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS = 2'd0,
    CFG_WAYS     = 2'd1,
    CFG_OFFSET   = 2'd2
  } cfg_idx_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

endpackage

`default_nettype wire

[sv/lcm_if.sv]
// Valid/ready channel interfaces for the input and result sides.
// Depends on lcm_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface lcm_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcm_pkg::ADDR_W-1:0]  address;
  logic                        mode;

  modport source (output valid, output address, output mode, input ready);
  modport sink   (input valid, input address, input mode, output ready);
endinterface

interface lcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcm_pkg::OUTCOME_W-1:0] outcome;
  logic                          last_of_item;
  logic [lcm_pkg::CNT_W-1:0]     hit_total;
  logic [lcm_pkg::CNT_W-1:0]     miss_total;
  logic [lcm_pkg::CNT_W-1:0]     eviction_total;

  modport source (output valid, output outcome, output last_of_item, output hit_total,
                  output miss_total, output eviction_total, input ready);
  modport sink   (input valid, input outcome, input last_of_item, input hit_total,
                  input miss_total, input eviction_total, output ready);
endinterface

`default_nettype wire

[sv/lcm_split.sv]
// Address splitter: clamps the configuration and cuts an address into set and tag.
// Depends on lcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcm_split #(
  parameter int MAX_SET_BITS = lcm_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = lcm_pkg::MAX_WAYS_DEF,
  localparam int SIW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  localparam int WCW = $clog2(MAX_WAYS + 1)
) (
  input  wire logic [lcm_pkg::ADDR_W-1:0]     address,
  input  wire logic [lcm_pkg::SET_BITS_W-1:0] cfg_set_bits,
  input  wire logic [lcm_pkg::WAYS_CFG_W-1:0] cfg_ways,
  input  wire logic [lcm_pkg::OFFSET_W-1:0]   cfg_offset,
  output logic      [SIW-1:0]                 set_idx,
  output logic      [lcm_pkg::ADDR_W-1:0]     tag,
  output logic      [WCW-1:0]                 ways
);

  localparam logic [3:0] MaxSb = 4'(MAX_SET_BITS);
  localparam logic [5:0] MaxWy = 6'(MAX_WAYS);

  logic [3:0]                  sb;
  logic [6:0]                  tsum;
  logic [5:0]                  cw;
  logic [5:0]                  weff;
  logic [lcm_pkg::ADDR_W-1:0]  shifted;
  logic [lcm_pkg::ADDR_W-1:0]  set_full;

  always_comb begin
    sb       = (4'(cfg_set_bits) > MaxSb) ? MaxSb : 4'(cfg_set_bits);
    shifted  = address >> cfg_offset;
    set_full = shifted & ~({lcm_pkg::ADDR_W{1'b1}} << sb);
    set_idx  = set_full[SIW-1:0];
    tsum     = 7'(cfg_offset) + 7'(sb);
    // a shift of the whole word or more leaves no tag
    tag      = (tsum < 7'd64) ? (address >> tsum) : '0;
    cw       = 6'(cfg_ways);
    if (cw == 6'd0) begin
      weff = 6'd1;
    end else if (cw > MaxWy) begin
      weff = MaxWy;
    end else begin
      weff = cw;
    end
    ways = WCW'(weff);
  end

endmodule

`default_nettype wire

[sv/set_associative_lru_cache_model.sv]
// Top level: tag store of a set-associative cache with LRU replacement.
// Depends on lcm_pkg, lcm_if (lcm_in_if, lcm_out_if) and lcm_split.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+----------------------------------------------
//   in_ch    | in  | valid/ready      | address[63:0], mode
//   out_ch   | out | valid/ready      | outcome[1:0], last_of_item, hit/miss/eviction
//   cfg_*    | in  | write enable     | cfg_idx[1:0], cfg_data[5:0]
//
// An access passes through a split state, a scan of one way per cycle through the
// tag/stamp memory read port, whose read data is registered, and an update state.
// A single item makes one access, a modify item two. A hit ends the scan early.
// After reset a clearing pass zeroes the valid rows; in_ch stays not ready meanwhile.
// A stalled out_ch holds the update cycle only when the output register still holds
// an untaken result.
`timescale 1ns / 1ps
`default_nettype none

module set_associative_lru_cache_model #(
  parameter int MAX_SET_BITS = lcm_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = lcm_pkg::MAX_WAYS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lcm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [lcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  lcm_in_if.sink                               in_ch,
  lcm_out_if.source                            out_ch
);

  localparam int SIW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int WIW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW  = $clog2(MAX_WAYS + 1);
  localparam int AW   = lcm_pkg::ADDR_W;
  localparam int TW   = lcm_pkg::STAMP_W;
  localparam int CW   = lcm_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SPLIT = 5'b00100,
    S_SCAN  = 5'b01000,
    S_UPD   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [lcm_pkg::SET_BITS_W-1:0] set_bits_r;
  logic [lcm_pkg::WAYS_CFG_W-1:0] ways_cfg_r;
  logic [lcm_pkg::OFFSET_W-1:0]   offset_r;

  // item and access context
  logic [AW-1:0]  addr_r;
  logic           mode_r;
  logic           second_r, second_nxt;
  logic [SIW-1:0] set_r;
  logic [AW-1:0]  tag_r;
  logic [WCW-1:0] ways_r;
  logic [SIW-1:0] sp_set;
  logic [AW-1:0]  sp_tag;
  logic [WCW-1:0] sp_ways;
  logic [SIW-1:0] clr_r;

  // scan state
  logic [WCW-1:0] iss_r, iss_nxt;
  logic [WIW-1:0] cmp_r, cmp_nxt;
  logic           pend_r, pend_nxt;
  logic           hit_r, hit_nxt;
  logic [WIW-1:0] hit_way_r, hit_way_nxt;
  logic           inv_found_r, inv_found_nxt;
  logic [WIW-1:0] inv_way_r, inv_way_nxt;
  logic           vic_found_r, vic_found_nxt;
  logic [WIW-1:0] vic_way_r, vic_way_nxt;
  logic [TW-1:0]  vic_stamp_r, vic_stamp_nxt;

  // counters
  logic [TW-1:0] clock_r;
  logic [CW-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;

  // output register
  logic                          out_valid_r;
  logic [lcm_pkg::OUTCOME_W-1:0] out_outcome_r;
  logic                          out_last_r;
  logic [CW-1:0]                 out_hit_r, out_miss_r, out_evict_r;

  // store
  logic [AW-1:0]       tag_mem   [SETS][MAX_WAYS];
  logic [TW-1:0]       stamp_mem [SETS][MAX_WAYS];
  logic [MAX_WAYS-1:0] valid_mem [SETS];
  logic [AW-1:0]       tag_q;
  logic [TW-1:0]       stamp_q;
  logic [MAX_WAYS-1:0] vrow_q;

  logic                          upd_go;
  logic                          vbit;
  logic [WIW-1:0]                rd_way;
  logic [WIW-1:0]                wr_way;
  logic [lcm_pkg::OUTCOME_W-1:0] kind;
  logic [MAX_WAYS-1:0]           fill_mask;

  lcm_split #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_split (
    .address      (addr_r),
    .cfg_set_bits (set_bits_r),
    .cfg_ways     (ways_cfg_r),
    .cfg_offset   (offset_r),
    .set_idx      (sp_set),
    .tag          (sp_tag),
    .ways         (sp_ways)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.outcome      = out_outcome_r;
  assign out_ch.last_of_item = out_last_r;
  assign out_ch.hit_total    = out_hit_r;
  assign out_ch.miss_total   = out_miss_r;
  assign out_ch.eviction_total = out_evict_r;

  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);
  assign rd_way    = iss_r[WIW-1:0];
  assign fill_mask = MAX_WAYS'(1) << inv_way_r;

  always_comb begin
    if (hit_r) begin
      kind   = lcm_pkg::OUT_HIT;
      wr_way = hit_way_r;
    end else if (inv_found_r) begin
      kind   = lcm_pkg::OUT_FILL;
      wr_way = inv_way_r;
    end else begin
      kind   = lcm_pkg::OUT_EVICT;
      wr_way = vic_way_r;
    end
  end

  // sequencer and the shared compare unit
  always_comb begin
    state_nxt     = state_r;
    second_nxt    = second_r;
    iss_nxt       = iss_r;
    cmp_nxt       = cmp_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    hit_way_nxt   = hit_way_r;
    inv_found_nxt = inv_found_r;
    inv_way_nxt   = inv_way_r;
    vic_found_nxt = vic_found_r;
    vic_way_nxt   = vic_way_r;
    vic_stamp_nxt = vic_stamp_r;
    vbit          = vrow_q[cmp_r];
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == SIW'(SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          second_nxt = 1'b0;
          state_nxt  = S_SPLIT;
        end
      end
      S_SPLIT: begin
        iss_nxt       = '0;
        pend_nxt      = 1'b0;
        hit_nxt       = 1'b0;
        inv_found_nxt = 1'b0;
        vic_found_nxt = 1'b0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        // next read goes out while the previous way is compared
        pend_nxt = (iss_r < ways_r);
        cmp_nxt  = iss_r[WIW-1:0];
        if (iss_r < ways_r) begin
          iss_nxt = iss_r + WCW'(1);
        end
        if (pend_r) begin
          if (vbit && (tag_q == tag_r)) begin
            hit_nxt     = 1'b1;
            hit_way_nxt = cmp_r;
            state_nxt   = S_UPD;
          end else begin
            if (!vbit && !inv_found_r) begin
              inv_found_nxt = 1'b1;
              inv_way_nxt   = cmp_r;
            end
            // strict compare keeps the lowest way on equal stamps
            if (vbit && (!vic_found_r || (stamp_q < vic_stamp_r))) begin
              vic_found_nxt = 1'b1;
              vic_way_nxt   = cmp_r;
              vic_stamp_nxt = stamp_q;
            end
            if (WCW'(cmp_r) == ways_r - WCW'(1)) begin
              state_nxt = S_UPD;
            end
          end
        end
      end
      S_UPD: begin
        if (upd_go) begin
          if (mode_r && !second_r) begin
            second_nxt = 1'b1;
            state_nxt  = S_SPLIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      second_r    <= 1'b0;
      pend_r      <= 1'b0;
      clock_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
      set_bits_r  <= '0;
      ways_cfg_r  <= lcm_pkg::WAYS_CFG_W'(1);
      offset_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      pend_r   <= pend_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + SIW'(1);
      end
      if (state_r == S_SPLIT) begin
        clock_r <= clock_r + TW'(1);
      end
      if (upd_go) begin
        unique case (kind)
          lcm_pkg::OUT_HIT:  hit_cnt_r <= hit_cnt_r + CW'(1);
          lcm_pkg::OUT_FILL: miss_cnt_r <= miss_cnt_r + CW'(1);
          default: begin
            miss_cnt_r  <= miss_cnt_r + CW'(1);
            evict_cnt_r <= evict_cnt_r + CW'(1);
          end
        endcase
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          lcm_pkg::CFG_SET_BITS: set_bits_r <= cfg_data[lcm_pkg::SET_BITS_W-1:0];
          lcm_pkg::CFG_WAYS:     ways_cfg_r <= cfg_data[lcm_pkg::WAYS_CFG_W-1:0];
          lcm_pkg::CFG_OFFSET:   offset_r   <= cfg_data[lcm_pkg::OFFSET_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      addr_r <= in_ch.address;
      mode_r <= in_ch.mode;
    end
    if (state_r == S_SPLIT) begin
      set_r  <= sp_set;
      tag_r  <= sp_tag;
      ways_r <= sp_ways;
    end
    iss_r       <= iss_nxt;
    cmp_r       <= cmp_nxt;
    hit_r       <= hit_nxt;
    hit_way_r   <= hit_way_nxt;
    inv_found_r <= inv_found_nxt;
    inv_way_r   <= inv_way_nxt;
    vic_found_r <= vic_found_nxt;
    vic_way_r   <= vic_way_nxt;
    vic_stamp_r <= vic_stamp_nxt;
    if (upd_go) begin
      out_outcome_r <= kind;
      out_last_r    <= !mode_r || second_r;
      out_hit_r     <= (kind == lcm_pkg::OUT_HIT) ? hit_cnt_r + CW'(1) : hit_cnt_r;
      out_miss_r    <= (kind == lcm_pkg::OUT_HIT) ? miss_cnt_r : miss_cnt_r + CW'(1);
      out_evict_r   <= (kind == lcm_pkg::OUT_EVICT) ? evict_cnt_r + CW'(1) : evict_cnt_r;
    end
  end

  // tag and stamp memory: one read port, one write port
  always_ff @(posedge clk) begin
    tag_q   <= tag_mem[set_r][rd_way];
    stamp_q <= stamp_mem[set_r][rd_way];
    if (upd_go) begin
      tag_mem[set_r][wr_way]   <= tag_r;
      stamp_mem[set_r][wr_way] <= clock_r;
    end
  end

  // valid rows, one row per set
  always_ff @(posedge clk) begin
    vrow_q <= valid_mem[set_r];
    if (state_r == S_CLEAR) begin
      valid_mem[clr_r] <= '0;
    end else if (upd_go && (kind == lcm_pkg::OUT_FILL)) begin
      valid_mem[set_r] <= vrow_q | fill_mask;
    end
  end

endmodule

`default_nettype wire

[sv/lcm_checker.sv]
// Port-level checks on the LRU tag store, attached to the top level by bind.
// Depends on lcm_pkg and the top level set_associative_lru_cache_model.
`timescale 1ns / 1ps
`default_nettype none

module lcm_port_props (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [lcm_pkg::OUTCOME_W-1:0] outcome,
  input wire logic [lcm_pkg::CNT_W-1:0]     hit_total,
  input wire logic [lcm_pkg::CNT_W-1:0]     miss_total,
  input wire logic [lcm_pkg::CNT_W-1:0]     eviction_total
);

  localparam int CW = lcm_pkg::CNT_W;

  logic [CW-1:0] prev_hit_r, prev_miss_r, prev_evict_r;
  logic          out_xfer;

  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_hit_r   <= '0;
      prev_miss_r  <= '0;
      prev_evict_r <= '0;
    end else if (out_xfer) begin
      prev_hit_r   <= hit_total;
      prev_miss_r  <= miss_total;
      prev_evict_r <= eviction_total;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an input transfer");

  a_one_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> CW'((hit_total - prev_hit_r) + (miss_total - prev_miss_r)) == CW'(1))
    else $error("hit and miss totals did not advance by exactly one");

  a_evict_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> ((outcome == lcm_pkg::OUT_EVICT) ?
                  (CW'(eviction_total - prev_evict_r) == CW'(1)) :
                  (eviction_total == prev_evict_r)))
    else $error("eviction total disagrees with outcome");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channels active straight after reset");

endmodule

bind set_associative_lru_cache_model lcm_port_props u_lcm_port_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .outcome        (out_ch.outcome),
  .hit_total      (out_ch.hit_total),
  .miss_total     (out_ch.miss_total),
  .eviction_total (out_ch.eviction_total)
);

`default_nettype wire

[bench/lcm_checker.sv]
`timescale 1ns / 1ps
// Result checker for the set-associative LRU tag store: follows register writes and both
// channels, predicts every access outcome and running count, and compares each transfer.
// Depends on lcm_pkg and the lcm_in_if / lcm_out_if interfaces.

module lcm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  lcm_in_if                               in_mon,
  lcm_out_if                              out_mon,
  output int                              fail_count,
  output int                              outstanding,
  output int                              items_seen,
  output int                              results_seen,
  output int                              hits_seen,
  output int                              fills_seen,
  output int                              evicts_seen
);
  import lcm_pkg::*;

  localparam int WAYS     = MAX_WAYS_DEF;
  localparam int SET_BITS = MAX_SET_BITS_DEF;
  localparam int LINES    = (1 << SET_BITS) * WAYS;

  typedef struct packed {
    outcome_t         outcome;
    logic             last_flag;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } access_result_t;

  logic                  line_live    [LINES];
  logic [ADDR_W-1:0]     line_tag_q   [LINES];
  logic [STAMP_W-1:0]    line_stamp_q [LINES];
  logic [STAMP_W-1:0]    access_clock;
  logic [CNT_W-1:0]      hit_cnt;
  logic [CNT_W-1:0]      miss_cnt;
  logic [CNT_W-1:0]      evict_cnt;
  logic [SET_BITS_W-1:0] set_bits_r;
  logic [WAYS_CFG_W-1:0] ways_r;
  logic [OFFSET_W-1:0]   offset_r;

  access_result_t due_results[$];

  // One lookup: hit refreshes the stamp, else first empty way, else oldest stamp goes.
  function automatic outcome_t lru_lookup(input logic [ADDR_W-1:0] addr);
    int sb;
    int bb;
    int nw;
    int base;
    int way;
    int hit_way;
    int free_way;
    int victim;
    logic [ADDR_W-1:0] set_no;
    logic [ADDR_W-1:0] tag;
    sb = (int'(set_bits_r) > SET_BITS) ? SET_BITS : int'(set_bits_r);
    nw = (ways_r == '0) ? 1 : ((int'(ways_r) > WAYS) ? WAYS : int'(ways_r));
    bb = int'(offset_r);
    access_clock = access_clock + 1'b1;
    set_no = (addr >> bb) & ((64'd1 << sb) - 64'd1);
    // offset plus set bits may swallow the whole address
    tag = (sb + bb < ADDR_W) ? (addr >> (sb + bb)) : '0;
    base = int'(set_no) * WAYS;
    hit_way = -1;
    free_way = -1;
    for (way = 0; way < nw; way++) begin
      if (hit_way < 0 && line_live[base+way] && line_tag_q[base+way] == tag) hit_way = way;
      if (free_way < 0 && !line_live[base+way]) free_way = way;
    end
    if (hit_way >= 0) begin
      hit_cnt = hit_cnt + 1'b1;
      line_stamp_q[base+hit_way] = access_clock;
      return OUT_HIT;
    end
    miss_cnt = miss_cnt + 1'b1;
    if (free_way >= 0) begin
      line_live[base+free_way]    = 1'b1;
      line_tag_q[base+free_way]   = tag;
      line_stamp_q[base+free_way] = access_clock;
      return OUT_FILL;
    end
    victim = 0;
    for (way = 1; way < nw; way++) begin
      if (line_stamp_q[base+way] < line_stamp_q[base+victim]) victim = way;
    end
    evict_cnt = evict_cnt + 1'b1;
    line_tag_q[base+victim]   = tag;
    line_stamp_q[base+victim] = access_clock;
    return OUT_EVICT;
  endfunction

  task automatic take_item();
    int n;
    int k;
    access_result_t r;
    n = in_mon.mode ? 2 : 1;
    items_seen++;
    for (k = 0; k < n; k++) begin
      r.outcome   = lru_lookup(in_mon.address);
      r.last_flag = (k == n - 1);
      r.hits      = hit_cnt;
      r.misses    = miss_cnt;
      r.evicts    = evict_cnt;
      due_results.push_back(r);
    end
    outstanding = due_results.size();
  endtask

  task automatic check_result();
    access_result_t want;
    logic bad;
    results_seen++;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: result transfer with nothing pending: outcome %0d hits %0d",
                 out_mon.outcome, out_mon.hit_total);
      return;
    end
    want = due_results.pop_front();
    outstanding = due_results.size();
    case (want.outcome)
      OUT_HIT:  hits_seen++;
      OUT_FILL: fills_seen++;
      default:  evicts_seen++;
    endcase
    bad = (out_mon.outcome !== want.outcome) || (out_mon.last_of_item !== want.last_flag) ||
          (out_mon.hit_total !== want.hits) || (out_mon.miss_total !== want.misses) ||
          (out_mon.eviction_total !== want.evicts);
    if (bad) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"ERROR: result %0d expected outcome %0d last %0b hits %0d misses %0d ",
                  "evictions %0d, got outcome %0d last %0b hits %0d misses %0d evictions %0d"},
                 results_seen, want.outcome, want.last_flag, want.hits, want.misses,
                 want.evicts, out_mon.outcome, out_mon.last_of_item, out_mon.hit_total,
                 out_mon.miss_total, out_mon.eviction_total);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        line_live[i]    = 1'b0;
        line_tag_q[i]   = '0;
        line_stamp_q[i] = '0;
      end
      access_clock = '0;
      hit_cnt      = '0;
      miss_cnt     = '0;
      evict_cnt    = '0;
      set_bits_r   = '0;
      ways_r       = WAYS_CFG_W'(1);
      offset_r     = '0;
      due_results.delete();
      fail_count   = 0;
      outstanding  = 0;
      items_seen   = 0;
      results_seen = 0;
      hits_seen    = 0;
      fills_seen   = 0;
      evicts_seen  = 0;
    end else begin
      // results leave before the item taken at the same edge can add any
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SET_BITS: set_bits_r = cfg_data[SET_BITS_W-1:0];
          CFG_WAYS:     ways_r     = cfg_data[WAYS_CFG_W-1:0];
          CFG_OFFSET:   offset_r   = cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_item();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for set_associative_lru_cache_model: clock, reset, register setups, directed
// and random access streams, idling on both channels and the verdict.
// Depends on lcm_pkg, lcm_in_if / lcm_out_if, the block and lcm_checker.

module tb_top;
  import lcm_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 45;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_req = 1'b0;

  lcm_in_if  in_ch ();
  lcm_out_if out_ch ();

  int fail_count;
  int outstanding;
  int items_seen;
  int results_seen;
  int hits_seen;
  int fills_seen;
  int evicts_seen;

  int burst_left;
  int eff_sb;
  int eff_ways;
  int eff_off;
  int n_setups;
  int n_tags;
  int n_sets;
  logic [ADDR_W-1:0] tag_pool [16];
  logic [ADDR_W-1:0] set_pool [4];

  set_associative_lru_cache_model dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  lcm_checker lru_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .items_seen   (items_seen),
    .results_seen (results_seen),
    .hits_seen    (hits_seen),
    .fills_seen   (fills_seen),
    .evicts_seen  (evicts_seen)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  // Receiver: changes its stall style now and then; a long hold-off on request.
  initial begin : receiver
    int style;
    int style_left;
    int hold_left;
    int rx_cycle;
    style = 0;
    style_left = 0;
    hold_left = 0;
    rx_cycle = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(32, 256);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ((rx_cycle % 5) != 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // spare high bits of the data word carry noise, the block must mask them
  task automatic apply_config(input int sb, input int ways, input int off);
    write_reg(CFG_SET_BITS, {3'($urandom), 3'(sb)});
    write_reg(CFG_WAYS, {2'($urandom), 4'(ways)});
    write_reg(CFG_OFFSET, 6'(off));
    cfg_we <= 1'b0;
    eff_sb   = (sb > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : sb;
    eff_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : ways);
    eff_off  = off;
    n_setups++;
  endtask

  task automatic send_item(input logic [ADDR_W-1:0] addr, input logic m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.address <= addr;
    in_ch.mode    <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic new_pools();
    int k;
    int tag_cap;
    tag_cap = (2 * eff_ways + 2 > 16) ? 16 : 2 * eff_ways + 2;
    n_sets = $urandom_range(1, 4);
    n_tags = $urandom_range(1, tag_cap);
    for (k = 0; k < 16; k++) tag_pool[k] = {$urandom, $urandom};
    for (k = 0; k < 4; k++) set_pool[k] = {$urandom, $urandom};
  endtask

  // Mostly a small working set packed into a few sets, so that hits and evictions
  // are frequent; the rest is wide noise and the address extremes.
  function automatic logic [ADDR_W-1:0] pick_address();
    int roll;
    int sh;
    logic [ADDR_W-1:0] low_mask;
    logic [ADDR_W-1:0] set_mask;
    roll = $urandom_range(0, 99);
    if (roll >= 95) return ($urandom_range(0, 1) != 0) ? {ADDR_W{1'b1}} : {ADDR_W{1'b0}};
    if (roll >= 85) return {$urandom, $urandom};
    sh = eff_sb + eff_off;
    low_mask = (64'd1 << eff_off) - 64'd1;
    set_mask = (64'd1 << eff_sb) - 64'd1;
    return (tag_pool[$urandom_range(0, n_tags - 1)] << sh) |
           ((set_pool[$urandom_range(0, n_sets - 1)] & set_mask) << eff_off) |
           ({$urandom, $urandom} & low_mask);
  endfunction

  initial begin : stimulus
    int phase;
    int i;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_SET_BITS;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.address <= '0;
    in_ch.mode    <= 1'b0;
    burst_left = 0;
    n_setups = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // four sets of two ways, 16-byte blocks: fill, hit, LRU victim choice
    apply_config(2, 2, 4);
    send_item(64'h0, 1'b0);
    send_item(64'h0, 1'b0);
    send_item(64'h40, 1'b1);
    send_item(64'hF, 1'b0);
    send_item(64'h80, 1'b0);
    send_item(64'h40, 1'b0);
    send_item({ADDR_W{1'b1}}, 1'b1);
    send_item(64'h8000_0000_0000_0000, 1'b0);
    drain_results();

    // set bits clamped, way count 0, offset 63: tag collapses to zero
    apply_config(7, 0, 63);
    send_item(64'h0, 1'b0);
    send_item({ADDR_W{1'b1}}, 1'b0);
    send_item(64'h8000_0000_0000_0000, 1'b1);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    drain_results();

    // offset plus set bits exactly 64, way count above the maximum
    apply_config(6, 15, 58);
    send_item({ADDR_W{1'b1}}, 1'b0);
    send_item(64'h0400_0000_0000_0000, 1'b1);
    drain_results();

    // one set, three ways: fills, eviction of the oldest, hit on a survivor
    apply_config(0, 3, 0);
    send_item(64'h10, 1'b0);
    send_item(64'h20, 1'b0);
    send_item(64'h30, 1'b0);
    send_item(64'h40, 1'b0);
    send_item(64'h20, 1'b0);
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_config(0, 1, 0);
        1: apply_config(6, 8, 0);
        2: apply_config(7, 15, 63);
        3: apply_config(3, 0, 5);
        4: apply_config(2, 4, 32);
        5: apply_config(1, 2, 6);
        6: apply_config(6, 8, 58);
        default: apply_config($urandom_range(0, 7), $urandom_range(0, 15),
                              $urandom_range(0, 63));
      endcase
      new_pools();
      // receiver holds off while the sender keeps offering, so the block backs up
      if (phase == 1) hold_req = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 4 && i == PHASE_ITEMS / 2) drain_results();
        send_item(pick_address(), 1'($urandom));
      end
      drain_results();
    end
    repeat (30) @(posedge clk);

    $display("Covered %0d items giving %0d accesses over %0d register setups",
             items_seen, results_seen, n_setups);
    $display("Outcomes seen: %0d hits, %0d fills, %0d evictions; %0d mismatches",
             hits_seen, fills_seen, evicts_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/lcm_pkg.sv
sv/lcm_if.sv
sv/lcm_split.sv
sv/set_associative_lru_cache_model.sv
sv/lcm_checker.sv
bench/lcm_checker.sv
bench/tb_top.sv
